// ===== rtl/set_median_by_sorting_core_assert.svh =====
// Assertion macros shared by the median core modules.
// Each macro fires on the rising clock edge and is disabled while reset is high.
`ifndef SET_MEDIAN_BY_SORTING_CORE_ASSERT_SVH
`define SET_MEDIAN_BY_SORTING_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that the consequent holds in the same cycle as the antecedent.
`define SMBS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("median core: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SMBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("median core: next-cycle check failed");

`else

`define SMBS_ASSERT_SAME(label, ante, cons)
`define SMBS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/smbs_pkg.sv =====
package smbs_pkg;

   localparam int MAX_COUNT   = 16;
   localparam int SAMPLE_BITS = 16;

   // Fixed field widths of the ports.
   localparam int SAMPLE_FIELD_BITS = 16;
   localparam int MEDIAN_FIELD_BITS = 17;
   localparam int COUNT_FIELD_BITS  = 5;

   // Internal widths derived from the capacity.
   localparam int CNT_BITS  = $clog2(MAX_COUNT + 1);
   localparam int SKIP_BITS = $clog2(MAX_COUNT);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [CNT_BITS-1:0]    count_type;
   typedef logic [SKIP_BITS-1:0]   skip_type;

   typedef struct packed {
      logic [SAMPLE_FIELD_BITS-1:0] sample_value;
      logic                         last_sample;
   } req_type;

   typedef struct packed {
      logic [MEDIAN_FIELD_BITS-1:0] median_doubled;
      logic [COUNT_FIELD_BITS-1:0]  set_count;
      logic                         overflow_flag;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic insert;
      logic shift;
      logic finish;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      count_type count_after;
   } dp_sts_type;

endpackage

// ===== rtl/smbs_datapath.sv =====
`include "set_median_by_sorting_core_assert.svh"

module smbs_datapath import smbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  dp_cmd_type cmd,
   output dp_sts_type sts,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   sample_type store_ff [MAX_COUNT];
   sample_type store_in [MAX_COUNT];
   count_type  count_ff, count_in;
   logic       dropped_ff, dropped_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   sample_type             new_sample;
   logic                   full;
   logic [MAX_COUNT-1:0]   le;
   logic [SAMPLE_BITS:0]   mid_sum;

   assign new_sample = sample_type'(req_data.sample_value);
   assign full       = (count_ff == count_type'(MAX_COUNT));

   assign sts.count_after = full ? count_ff : count_ff + count_type'(1);

   // Odd count: twice the middle cell; even: sum of the middle pair.
   assign mid_sum = count_ff[0] ? {store_ff[0], 1'b0}
                                : {1'b0, store_ff[0]} + {1'b0, store_ff[1]};

   // Entries at or below the new sample form a prefix of the sorted row.
   always_comb begin
      for (int i = 0; i < MAX_COUNT; i++) begin
         le[i] = (count_type'(i) < count_ff) && (store_ff[i] <= new_sample);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_COUNT; i++) begin
         store_in[i] = store_ff[i];
      end
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      if (cmd.insert) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + count_type'(1);
            for (int i = 0; i < MAX_COUNT; i++) begin
               if (!le[i]) begin
                  if (i == 0) begin
                     store_in[i] = new_sample;
                  end else if (le[i-1]) begin
                     store_in[i] = new_sample;
                  end else begin
                     store_in[i] = store_ff[i-1];
                  end
               end
            end
         end
      end

      // Walk the row down by one cell.
      if (cmd.shift) begin
         for (int i = 0; i < MAX_COUNT - 1; i++) begin
            store_in[i] = store_ff[i+1];
         end
      end

      if (cmd.finish) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.median_doubled = MEDIAN_FIELD_BITS'(mid_sum);
         rsp_data_in.set_count      = COUNT_FIELD_BITS'(count_ff);
         rsp_data_in.overflow_flag  = dropped_ff;
         count_in                   = '0;
         dropped_in                 = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_COUNT; i++) begin
         store_ff[i] <= store_in[i];
      end
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SMBS_ASSERT_NEXT(a_finish_clears, cmd.finish, rsp_valid_ff && (count_ff == '0) && !dropped_ff)
   `SMBS_ASSERT_NEXT(a_full_drops, cmd.insert && full, dropped_ff && (count_ff == $past(count_ff)))

endmodule

// ===== rtl/smbs_ctrl.sv =====
`include "set_median_by_sorting_core_assert.svh"

module smbs_ctrl import smbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       last_sample,
   input  dp_sts_type sts,
   output dp_cmd_type cmd,
   output logic       busy
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEEK = 2'b10
   } state_type;

   state_type state_ff, state_in;
   skip_type  skip_ff, skip_in;
   logic      accept;
   count_type below_mid;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Cells to drop from the bottom so the lower middle sits in cell zero.
   assign below_mid = (sts.count_after - count_type'(1)) >> 1;

   always_comb begin
      state_in   = state_ff;
      skip_in    = skip_ff;
      cmd.insert = 1'b0;
      cmd.shift  = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.insert = accept;
            if (accept && last_sample) begin
               state_in = ST_SEEK;
               skip_in  = skip_type'(below_mid);
            end
         end
         ST_SEEK: begin
            if (skip_ff == '0) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.shift = 1'b1;
               skip_in   = skip_ff - skip_type'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      skip_ff <= skip_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SMBS_ASSERT_SAME(a_no_insert_busy, busy, !cmd.insert)
   `SMBS_ASSERT_NEXT(a_close_seeks, accept && last_sample, state_ff == ST_SEEK)

endmodule

// ===== rtl/set_median_by_sorting_core.sv =====
// Median of a set of unsigned samples, kept sorted as they arrive.
// Drive a sample on req_data and raise start; the beat is taken on a rising
// edge where start is high and busy is low. A sample that is not marked last
// leaves busy low, so samples may follow back to back.
// A sample marked last closes the set: busy then stays high while the sorted
// row walks down one cell a cycle until the middle pair reaches its bottom
// end, and while the result is then formed. The result beat appears on
// rsp_data for exactly one cycle with rsp_valid high, registered after the
// walk ends and taken at the edge that follows. It cannot be held off:
// capture it then. median_doubled is twice the median, exact, with one
// fractional bit. Samples arriving while MAX_COUNT are held are dropped and
// flagged in overflow_flag. The block is empty again once the result has
// been issued.
module set_median_by_sorting_core import smbs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequence insertion, the walk down and the result beat.
   smbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .last_sample (req_data.last_sample),
      .sts         (sts),
      .cmd         (cmd),
      .busy        (busy)
   );

   // Hold the sorted row, the count and the drop flag; form the result.
   smbs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/set_median_by_sorting_core_check.sv =====
module set_median_by_sorting_core_check import smbs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      medians_owed
);

   timeunit 1ns;
   timeprecision 1ps;

   sample_type  ordered [MAX_COUNT];
   int unsigned held;
   logic        dropped;
   rsp_type     medians_due [$];
   rsp_type     oldest;

   // Insert one sample in ascending order; on the closing beat queue the median.
   task automatic take_sample(input req_type beat);
      sample_type                   value;
      int                           slot;
      logic [MEDIAN_FIELD_BITS-1:0] lower;
      logic [MEDIAN_FIELD_BITS-1:0] upper;
      rsp_type                      due;
      value = beat.sample_value[SAMPLE_BITS-1:0];
      if (held < MAX_COUNT) begin
         slot = held;
         while (slot > 0 && ordered[slot-1] > value) begin
            ordered[slot] = ordered[slot-1];
            slot--;
         end
         ordered[slot] = value;
         held++;
      end else begin
         dropped = 1'b1;
      end
      if (beat.last_sample) begin
         if (held % 2 == 0) begin
            lower = MEDIAN_FIELD_BITS'(ordered[held/2-1]);
            upper = MEDIAN_FIELD_BITS'(ordered[held/2]);
            due.median_doubled = lower + upper;
         end else begin
            upper = MEDIAN_FIELD_BITS'(ordered[held/2]);
            due.median_doubled = upper << 1;
         end
         due.set_count     = held[COUNT_FIELD_BITS-1:0];
         due.overflow_flag = dropped;
         medians_due.push_back(due);
         held    = 0;
         dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held           = 0;
         dropped        = 1'b0;
         mismatch_count = 0;
         medians_due.delete();
      end else begin
         // Results come before the beat taken on the same edge.
         if (rsp_valid) begin
            if (medians_due.size() == 0) begin
               $display("%0t: unexpected result, median_doubled %0d set_count %0d overflow %0d",
                        $time, rsp_data.median_doubled, rsp_data.set_count,
                        rsp_data.overflow_flag);
               mismatch_count++;
            end else begin
               oldest = medians_due.pop_front();
               if (rsp_data.median_doubled !== oldest.median_doubled) begin
                  $display("%0t: median_doubled expected %0d actual %0d",
                           $time, oldest.median_doubled, rsp_data.median_doubled);
                  mismatch_count++;
               end
               if (rsp_data.set_count !== oldest.set_count) begin
                  $display("%0t: set_count expected %0d actual %0d",
                           $time, oldest.set_count, rsp_data.set_count);
                  mismatch_count++;
               end
               if (rsp_data.overflow_flag !== oldest.overflow_flag) begin
                  $display("%0t: overflow_flag expected %0d actual %0d",
                           $time, oldest.overflow_flag, rsp_data.overflow_flag);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            take_sample(req_data);
         end
      end
      medians_owed = medians_due.size();
   end

endmodule

// ===== sim/set_median_by_sorting_core_test.sv =====
module set_median_by_sorting_core_test import smbs_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no beat on either channel before the run is abandoned.
   localparam int IDLE_LIMIT    = 2000;
   // Longest busy stretch after a closing beat, plus the result cycle and margin.
   localparam int SETTLE_CYCLES = MAX_COUNT / 2 + 4;
   localparam int RANDOM_BEATS  = 1200;

   // Value styles for a random set.
   typedef enum int {WIDE, CLUSTERED, EXTREMES, HIGH_BAND} spread_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatch_count;
   int medians_owed;
   int idle_cycles;
   bit steady;

   set_median_by_sorting_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   set_median_by_sorting_core_check checker_inst (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .medians_owed   (medians_owed)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Watchdog: count edges at which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("set_median_by_sorting_core verification failed");
            $finish;
         end
      end
   end

   // Present one beat at the falling edge after a drawn gap, then hold it
   // until a rising edge finds busy low. Return on the following falling edge,
   // with start still high so that a back-to-back beat needs no re-raise.
   task automatic send_beat(input logic [SAMPLE_FIELD_BITS-1:0] value,
                            input logic closing);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.sample_value = value;
      req_data.last_sample  = closing;
      start                 = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending until every owed median has been seen.
   task automatic drain_medians();
      start = 1'b0;
      wait (medians_owed == 0);
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_FIELD_BITS-1:0] pick_sample(input spread_type spread);
      logic [SAMPLE_FIELD_BITS-1:0] value;
      case (spread)
         CLUSTERED: value = SAMPLE_FIELD_BITS'($urandom_range(0, 3));
         EXTREMES:  value = $urandom_range(0, 1)
                          ? 16'hFFFF - SAMPLE_FIELD_BITS'($urandom_range(0, 1))
                          : SAMPLE_FIELD_BITS'($urandom_range(0, 1));
         HIGH_BAND: value = SAMPLE_FIELD_BITS'($urandom_range(65000, 65535));
         default:   value = SAMPLE_FIELD_BITS'($urandom_range(0, 65535));
      endcase
      return value;
   endfunction

   task automatic send_random_set(input int size);
      spread_type spread;
      spread = spread_type'($urandom_range(0, 3));
      for (int i = 0; i < size; i++) begin
         send_beat(pick_sample(spread), i == size - 1);
      end
   endtask

   initial begin
      int beats_sent;
      int size;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      steady   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Single-sample sets at both ends of the range.
      send_beat(16'h0000, 1'b1);
      send_beat(16'hFFFF, 1'b1);
      // Largest possible median: two full-scale samples.
      send_beat(16'hFFFF, 1'b0);
      send_beat(16'hFFFF, 1'b1);
      // Even count with an odd sum: the fractional bit is set.
      send_beat(16'h0001, 1'b0);
      send_beat(16'h0000, 1'b1);
      // Equal samples go in after their equals.
      steady = 1'b1;
      repeat (2) send_beat(16'h5A5A, 1'b0);
      send_beat(16'h5A5A, 1'b1);
      // Descending fill to capacity; the closing beat finds the store full,
      // is dropped, and still closes the set with the overflow flag raised.
      steady = 1'b0;
      for (int i = 0; i <= MAX_COUNT; i++) begin
         send_beat(16'((MAX_COUNT - i) * 4095), i == MAX_COUNT);
      end
      drain_medians();

      // Random sets: mostly within capacity, some that overflow, with bursts
      // of back-to-back beats and the occasional full drain.
      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) begin
         if ($urandom_range(0, 7) == 0) begin
            size = $urandom_range(MAX_COUNT + 1, MAX_COUNT + 8);
         end else begin
            size = $urandom_range(1, MAX_COUNT);
         end
         steady = ($urandom_range(0, 3) == 0);
         send_random_set(size);
         beats_sent += size;
         if ($urandom_range(0, 19) == 0) begin
            drain_medians();
         end
      end

      // Drop start, wait for the last median, then let the block settle.
      start = 1'b0;
      wait (medians_owed == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("set_median_by_sorting_core verification clean");
      end else begin
         $display("set_median_by_sorting_core verification failed");
      end
      $finish;
   end

endmodule

// ===== set_median_by_sorting_core.f =====
+incdir+rtl
rtl/smbs_pkg.sv
rtl/smbs_datapath.sv
rtl/smbs_ctrl.sv
rtl/set_median_by_sorting_core.sv
sim/set_median_by_sorting_core_check.sv
sim/set_median_by_sorting_core_test.sv
